>>> rtl/core/dvf_pkg.sv
// Package for the distinct value filter.
// It holds the transfer payload types, the per-item flag group and the field constants.
// It depends on nothing else.
package dvf_pkg;

   // Widths of the transfer fields.
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 11;

   // The largest distinct count that the result field can show.
   localparam int COUNT_MAX = 2047;

   // Input payload: one value of the current list.
   typedef struct packed {
      logic signed [VALUE_W-1:0] sample_value;
      logic                      last_in_list;
   } req_type;

   // Result payload: one result for each accepted value.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value_out;
      logic                      is_new;
      logic [COUNT_W-1:0]        distinct_count;
      logic                      table_overflow;
      logic                      list_done;
   } rsp_type;

   // Status that travels with an item from cell to cell.
   typedef struct packed {
      logic valid;
      logic last;
      logic matched;
      logic stored;
   } dvf_flags_type;

endpackage

>>> rtl/core/distinct_value_filter.sv
// An input transfer reaches the result register through the row of cells, one register stage per cell.
// Throughput: one item per cycle unless stalled; each walks the whole row behind the one before.
// The row moves only when the result register is empty or its transfer completes.
// Reset empties the table and the row; no clearing pass is needed.
// Depends on dvf_pkg and dvf_cell.
module distinct_value_filter #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dvf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dvf_pkg::rsp_type rsp_data
);

   localparam int CountWidth = $clog2(TABLE_DEPTH + 1);

   dvf_pkg::dvf_flags_type      chain_flags [TABLE_DEPTH+1];
   logic [dvf_pkg::VALUE_W-1:0] chain_value [TABLE_DEPTH+1];
   logic [CountWidth-1:0]       chain_count [TABLE_DEPTH+1];
   logic                        advance;
   logic [31:0]                 count_wide;
   dvf_pkg::dvf_flags_type      tail;

   // The whole row moves together unless the finished result is held up.
   assign advance   = !chain_flags[TABLE_DEPTH].valid || !rsp_stall;
   assign req_stall = !advance;

   // A new item enters with no match, no store and a zero count.
   assign chain_flags[0] = '{valid:   req_valid,
                             last:    req_data.last_in_list,
                             matched: 1'b0,
                             stored:  1'b0};
   assign chain_value[0] = req_data.sample_value;
   assign chain_count[0] = '0;

   // The row of cells, one table entry each.
   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      dvf_cell #(
         .CountWidth(CountWidth)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_flags  (chain_flags[k]),
         .in_value  (chain_value[k]),
         .in_count  (chain_count[k]),
         .out_flags (chain_flags[k+1]),
         .out_value (chain_value[k+1]),
         .out_count (chain_count[k+1])
      );
   end

   // The last cell's stage is the result register.
   assign tail       = chain_flags[TABLE_DEPTH];
   assign count_wide = 32'(chain_count[TABLE_DEPTH]);
   assign rsp_valid  = tail.valid;

   always_comb begin
      rsp_data.value_out      = chain_value[TABLE_DEPTH];
      rsp_data.is_new         = tail.stored;
      rsp_data.table_overflow = !tail.matched && !tail.stored;
      rsp_data.list_done      = tail.last;
      if (count_wide > 32'(dvf_pkg::COUNT_MAX)) begin
         rsp_data.distinct_count = dvf_pkg::COUNT_W'(dvf_pkg::COUNT_MAX);
      end else begin
         rsp_data.distinct_count = count_wide[dvf_pkg::COUNT_W-1:0];
      end
   end

`ifndef NO_ASSERTIONS
   // A value is either stored, matched or dropped, never stored and dropped.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.is_new && rsp_data.table_overflow))
      else $error("result is both new and overflow");

   // A stored value always leaves a nonzero count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_new |-> rsp_data.distinct_count != '0)
      else $error("new value with zero distinct count");

   // A repeat can only match something already in the table.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_new && !rsp_data.table_overflow
         |-> rsp_data.distinct_count != '0)
      else $error("repeat reported with an empty table");

   // A dropped value means the table was full.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_overflow
         |-> count_wide == 32'(TABLE_DEPTH))
      else $error("overflow reported with room in the table");
`endif

endmodule

>>> rtl/core/dvf_cell.sv
// One cell of the filter chain: it holds one table entry and one item stage.
// It depends on dvf_pkg for the flag group type and the value width.
module dvf_cell #(
   parameter int CountWidth = 11
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  dvf_pkg::dvf_flags_type              in_flags,
   input  logic [dvf_pkg::VALUE_W-1:0]         in_value,
   input  logic [CountWidth-1:0]               in_count,
   output dvf_pkg::dvf_flags_type              out_flags,
   output logic [dvf_pkg::VALUE_W-1:0]         out_value,
   output logic [CountWidth-1:0]               out_count
);

   logic [dvf_pkg::VALUE_W-1:0] entry_ff;
   logic                        filled_ff;
   logic                        filled_in;
   dvf_pkg::dvf_flags_type      flags_ff;
   dvf_pkg::dvf_flags_type      flags_in;
   logic [dvf_pkg::VALUE_W-1:0] value_ff;
   logic [CountWidth-1:0]       count_ff;
   logic [CountWidth-1:0]       count_in;
   logic                        hit;
   logic                        take;

   // The item matches a stored entry, or claims this cell as the first empty one.
   assign hit  = in_flags.valid && filled_ff && (entry_ff == in_value);
   assign take = in_flags.valid && !filled_ff && !in_flags.matched && !in_flags.stored;

   // The item counts every occupied cell that it passes, its own store included.
   assign count_in = in_count + CountWidth'(filled_ff || take);

   always_comb begin
      flags_in.valid   = in_flags.valid;
      flags_in.last    = in_flags.last;
      flags_in.matched = in_flags.matched || hit;
      flags_in.stored  = in_flags.stored || take;
   end

   // The filled bits of the row form the fill count in unary; the last item of a
   // list empties each cell as it passes.
   always_comb begin
      filled_in = filled_ff;
      if (in_flags.valid) begin
         if (in_flags.last) begin
            filled_in = 1'b0;
         end else if (take) begin
            filled_in = 1'b1;
         end
      end
   end

   // Control state of the cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= 1'b0;
         flags_ff  <= '0;
      end else if (advance) begin
         filled_ff <= filled_in;
         flags_ff  <= flags_in;
      end
   end

   // Entry and item payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         if (take) begin
            entry_ff <= in_value;
         end
         value_ff <= in_value;
         count_ff <= count_in;
      end
   end

   assign out_flags = flags_ff;
   assign out_value = value_ff;
   assign out_count = count_ff;

endmodule

>>> tb/distinct_value_checker.sv
// Scoreboard for the distinct value filter: it predicts every result and checks it.
// It watches both channels of the block and reports a mismatch count and the open results.
// Depends on dvf_pkg.
`timescale 1ns / 1ps

module distinct_value_checker #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  dvf_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  dvf_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               pending_results
);

   // Past this many reports a broken block would only flood the log.
   localparam int REPORT_LIMIT = 100;

   // Our own copy of the table of distinct values in the current list.
   logic [dvf_pkg::VALUE_W-1:0] list_values [TABLE_DEPTH];
   int unsigned                 list_count;

   // Results predicted for accepted values, oldest first.
   dvf_pkg::rsp_type            expected_results [$];

   initial begin
      mismatch_count  = 0;
      pending_results = 0;
      list_count      = 0;
   end

   // Looks the value up, stores it if there is room and builds the result.
   function automatic dvf_pkg::rsp_type filter_value(input dvf_pkg::req_type item);
      dvf_pkg::rsp_type res;
      bit               found;
      int unsigned      shown;
      found = 0;
      for (int k = 0; k < list_count; k++) begin
         if (list_values[k] == item.sample_value) begin
            found = 1;
         end
      end
      res                = '0;
      res.value_out      = item.sample_value;
      res.list_done      = item.last_in_list;
      if (!found) begin
         if (list_count < TABLE_DEPTH) begin
            list_values[list_count] = item.sample_value;
            list_count++;
            res.is_new = 1'b1;
         end else begin
            res.table_overflow = 1'b1;
         end
      end
      shown              = (list_count > dvf_pkg::COUNT_MAX) ? dvf_pkg::COUNT_MAX : list_count;
      res.distinct_count = dvf_pkg::COUNT_W'(shown);
      // The table is emptied once the result for the last value of the list is built.
      if (item.last_in_list) begin
         list_count = 0;
      end
      return res;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $error("%s: expected 0x%08h, actual 0x%08h", field, want, got);
         end
      end
   endtask

   // Results are checked before new values are predicted within one edge.
   always @(posedge clock) begin
      dvf_pkg::rsp_type want;
      if (reset) begin
         list_count = 0;
         expected_results.delete();
         pending_results = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $error("result transfer with no value outstanding: value_out 0x%08h",
                         rsp_data.value_out);
               end
            end else begin
               want = expected_results.pop_front();
               check_field("value_out", want.value_out, rsp_data.value_out);
               check_field("is_new", want.is_new, rsp_data.is_new);
               check_field("distinct_count", want.distinct_count, rsp_data.distinct_count);
               check_field("table_overflow", want.table_overflow, rsp_data.table_overflow);
               check_field("list_done", want.list_done, rsp_data.list_done);
            end
         end
         if (req_valid && !req_stall) begin
            expected_results.push_back(filter_value(req_data));
         end
         pending_results = expected_results.size();
      end
   end

endmodule

>>> tb/tb_distinct_value_filter.sv
// Top of the distinct value filter testbench: clock, reset, value lists and the verdict.
// Prediction and checking sit in distinct_value_checker.
// Depends on dvf_pkg, distinct_value_filter and distinct_value_checker.
`timescale 1ns / 1ps

module tb_distinct_value_filter;

   localparam int     TABLE_DEPTH  = 1024;
   localparam int     RANDOM_ITEMS = 2000;
   localparam longint CYCLE_LIMIT  = 2_000_000;
   localparam int     NUM_DIRECTED = 17;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             rsp_stall = 1'b0;
   dvf_pkg::req_type req_data  = '0;
   logic             req_stall;
   logic             rsp_valid;
   dvf_pkg::rsp_type rsp_data;

   int      mismatch_count;
   int      pending_results;
   int      items_sent    = 0;
   bit      steady_sender = 0;
   longint  cycle_count   = 0;

   distinct_value_filter #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   distinct_value_checker #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_results(pending_results)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Idle stretches are mostly short, with an occasional long one.
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Offers one value, waits for its transfer, then idles for a while unless the sender is steady.
   task automatic send_value(input logic [dvf_pkg::VALUE_W-1:0] value, input logic last);
      int gap;
      @(negedge clock);
      req_valid             <= 1'b1;
      req_data.sample_value <= value;
      req_data.last_in_list <= last;
      do @(posedge clock); while (req_stall);
      items_sent++;
      gap = steady_sender ? 0 : idle_length();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Stops offering until every outstanding result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_results == 0);
   endtask

   // One list that fills the table and may run past it, so that unseen values
   // are dropped and flagged; dropped values are repeated to flag them again.
   task automatic run_fill_list();
      logic [dvf_pkg::VALUE_W-1:0] history [$];
      logic [dvf_pkg::VALUE_W-1:0] base;
      logic [dvf_pkg::VALUE_W-1:0] step;
      logic [dvf_pkg::VALUE_W-1:0] value;
      int                          fresh;
      int                          past_full;
      base          = $urandom;
      step          = $urandom | 32'd1;
      fresh         = 0;
      past_full     = $urandom_range(0, 60);
      steady_sender = 0;
      while (fresh < TABLE_DEPTH + past_full) begin
         if (fresh >= TABLE_DEPTH && history.size() > TABLE_DEPTH &&
             $urandom_range(0, 2) == 0) begin
            value = history[$urandom_range(TABLE_DEPTH, history.size() - 1)];
         end else if (history.size() > 0 && $urandom_range(0, 9) == 0) begin
            value = history[$urandom_range(0, history.size() - 1)];
         end else begin
            // An odd step keeps every generated value distinct.
            value = base + step * 32'(fresh);
            fresh++;
            history.push_back(value);
         end
         send_value(value, fresh == TABLE_DEPTH + past_full);
      end
   endtask

   // A short list mixing fresh values, repeats, small values and extremes.
   task automatic run_short_list();
      logic [dvf_pkg::VALUE_W-1:0] history [$];
      logic [dvf_pkg::VALUE_W-1:0] value;
      int                          length;
      int                          pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) length = $urandom_range(1, 12);
      else if (pick < 95) length = $urandom_range(13, 60);
      else length = $urandom_range(61, 200);
      steady_sender = ($urandom_range(0, 4) == 0);
      for (int n = 0; n < length; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40 || history.size() == 0) begin
            value = $urandom;
         end else if (pick < 70) begin
            value = history[$urandom_range(0, history.size() - 1)];
         end else if (pick < 92) begin
            // Small values recur both within a list and across lists.
            value = $urandom_range(0, 15);
         end else begin
            case ($urandom_range(0, 3))
               0: value = 32'h8000_0000;
               1: value = 32'h7FFF_FFFF;
               2: value = 32'hFFFF_FFFF;
               default: value = 32'h0000_0000;
            endcase
         end
         history.push_back(value);
         send_value(value, n == length - 1);
      end
   endtask

   // Result side: alternating ready runs and stalls, plus one long hold-off
   // once a few dozen results are outstanding so that the block backs up into
   // its input while the sender keeps offering.
   initial begin
      int run_left;
      bit stalling;
      bit long_hold_done;
      run_left       = 0;
      stalling       = 0;
      long_hold_done = 0;
      forever begin
         @(negedge clock);
         if (!reset && !long_hold_done && pending_results >= 32) begin
            long_hold_done = 1;
            stalling       = 1;
            run_left       = 3000;
         end else if (run_left == 0) begin
            stalling = !stalling;
            if (stalling) begin
               run_left = idle_length() + 1;
            end else if ($urandom_range(0, 9) == 0) begin
               run_left = $urandom_range(50, 300);
            end else begin
               run_left = $urandom_range(1, 20);
            end
         end
         run_left--;
         rsp_stall <= stalling;
      end
   end

   // Watchdog on the total run length.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_distinct_value_filter: FAIL");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      logic [dvf_pkg::VALUE_W-1:0] directed_values [NUM_DIRECTED];
      bit                          directed_last   [NUM_DIRECTED];
      // Single-value list; extremes with repeats and a repeat as last value;
      // an immediate repeat and a value new again after the table was emptied.
      directed_values = '{32'h0000_0000,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                          32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF,
                          32'h0000_0001, 32'hFFFF_FFFF,
                          32'h0000_0000, 32'h0000_0000, 32'h8000_0000,
                          32'h0000_0005, 32'hFFFF_FFFB, 32'h0000_0005};
      directed_last   = '{1,
                          0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                          0, 0, 1,
                          0, 0, 1};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      steady_sender = 0;
      for (int n = 0; n < NUM_DIRECTED; n++) begin
         send_value(directed_values[n], directed_last[n]);
      end
      drain_results();

      // Random lists: one that fills the table and may overflow it, then many short ones.
      items_sent = 0;
      run_fill_list();
      drain_results();
      while (items_sent < RANDOM_ITEMS) begin
         run_short_list();
         if ($urandom_range(0, 9) == 0) begin
            drain_results();
         end
      end

      drain_results();
      repeat (TABLE_DEPTH + 64) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("tb_distinct_value_filter: PASS");
      end else begin
         $display("tb_distinct_value_filter: FAIL");
      end
      $finish;
   end

endmodule
